// File: rtl/csvft_pkg.sv
// ----------------------------------------------------------------------------
// csvft_pkg: shared types and constants for the CSV field tokenizer
// Byte classes passed from the front to the back, quote mode codes,
// result kinds and the fixed limits of a cell and of a row.
// ----------------------------------------------------------------------------
package csvft_pkg;

	// Limits of one cell and one row
	localparam int MAX_CELL_BYTES = 4096;
	localparam int MAX_ROW_CELLS  = 256;

	// Counter widths follow from the limits
	localparam int BC_W = $clog2(MAX_CELL_BYTES + 1);
	localparam int CC_W = $clog2(MAX_ROW_CELLS + 1);

	// Fixed field widths
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 8;
	localparam int LEN_W   = 13;
	localparam int KIND_W  = 2;
	localparam int MAXC_W  = 9;
	localparam int CFGI_W  = 2;
	localparam int CFGD_W  = 9;
	localparam int TDATA_W = 32;

	// Special characters and register defaults
	localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [BYTE_W-1:0] DELIM_RST  = 8'h2C;
	localparam logic [MAXC_W-1:0] MAXC_RST   = 9'd256;

	// Configuration register indexes
	localparam logic [CFGI_W-1:0] REG_DELIMITER = 2'd0;
	localparam logic [CFGI_W-1:0] REG_MAX_CELLS = 2'd1;

	// Byte class decided by the front
	typedef enum logic [2:0] {
		CLS_DATA    = 3'd0,
		CLS_QUOTE   = 3'd1,
		CLS_NEWLINE = 3'd2,
		CLS_DELIM   = 3'd3,
		CLS_EOI     = 3'd4
	} cls_t;

	// One queued item
	typedef struct packed {
		cls_t              cls;
		logic [BYTE_W-1:0] data;
	} entry_t;

	// Quote mode state
	typedef enum logic [2:0] {
		QM_OUTSIDE = 3'b001,
		QM_INSIDE  = 3'b010,
		QM_QSEEN   = 3'b100
	} qmode_t;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_DATA     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CELL_END = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ROW_END  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ABORT    = 2'd3;

endpackage

// File: rtl/csv_field_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit: streaming CSV cell tokenizer
// Bytes of CSV text enter on the s_ channel, one per item; s_tuser set
// marks end of input instead of a byte. Results leave on the m_ channel:
// content bytes, cell ends and row ends with cell index and length, and
// an abort kind when input ends inside an open quote.
// A classifier tags each byte, a four-entry queue holds tagged items and
// the back end runs the quote machine and counters, one item per cycle
// while the output register is free or being read. Each result passes
// through the queue and then the output register. Items that give no
// result (opening quotes, the first quote of a pair inside a quoted cell,
// end of input with an empty row) leave the queue without loading the
// output register. When the receiver stalls the result is held in the
// output register, the queue fills and s_tready drops once four items wait.
// Reset clears the row state, empties the queue and restores the
// delimiter to comma and the cell limit to 256. Configuration is written
// through cfg_we, cfg_index and cfg_data; the user must write it only
// while the block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [csvft_pkg::CFGI_W-1:0]  cfg_index,
	input  logic [csvft_pkg::CFGD_W-1:0]  cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] in_byte
	input  logic                          s_tuser,  // [0] end_of_input
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,  // [7:0] out_byte, [15:8] cell_index,
	                                                // [28:16] cell_len, [29] overflow
	output logic [1:0]                    m_tuser   // [1:0] out_kind
);

	csvft_pkg::entry_t front_entry;
	csvft_pkg::entry_t head;
	logic              full;
	logic              not_empty;
	logic              pop;

	// Classify incoming bytes
	csvft_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_byte      (s_tdata),
		.end_of_input (s_tuser),
		.entry        (front_entry)
	);

	assign s_tready = !full;

	// Hold classified items between front and back
	csvft_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s_tvalid),
		.push_entry (front_entry),
		.full       (full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	// Tokenize and drive results
	csvft_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (not_empty),
		.q_head    (head),
		.q_pop     (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// File: rtl/csvft_front.sv
// ----------------------------------------------------------------------------
// csvft_front: input classifier
// Holds the delimiter register and tags each incoming item as quote,
// newline, delimiter, plain data or end of input.
// ----------------------------------------------------------------------------
module csvft_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [csvft_pkg::CFGI_W-1:0]   cfg_index,
	input  logic [csvft_pkg::CFGD_W-1:0]   cfg_data,
	input  logic [csvft_pkg::BYTE_W-1:0]   in_byte,
	input  logic                           end_of_input,
	output csvft_pkg::entry_t              entry
);

	logic [csvft_pkg::BYTE_W-1:0] delimiter_q;

	// Delimiter register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= csvft_pkg::DELIM_RST;
		end else if (cfg_we && cfg_index == csvft_pkg::REG_DELIMITER) begin
			delimiter_q <= cfg_data[csvft_pkg::BYTE_W-1:0];
		end
	end

	// Classify: quote beats newline, newline beats delimiter
	always_comb begin
		entry.data = in_byte;
		if (end_of_input)
			entry.cls = csvft_pkg::CLS_EOI;
		else if (in_byte == csvft_pkg::CH_QUOTE)
			entry.cls = csvft_pkg::CLS_QUOTE;
		else if (in_byte == csvft_pkg::CH_NEWLINE)
			entry.cls = csvft_pkg::CLS_NEWLINE;
		else if (in_byte == delimiter_q)
			entry.cls = csvft_pkg::CLS_DELIM;
		else
			entry.cls = csvft_pkg::CLS_DATA;
	end

endmodule

// File: rtl/csvft_queue.sv
// ----------------------------------------------------------------------------
// csvft_queue: four-entry item queue
// Decouples the classifier from the tokenizer back end; push and pop
// may happen in the same cycle.
// ----------------------------------------------------------------------------
module csvft_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csvft_pkg::entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output csvft_pkg::entry_t head
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	csvft_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == (PTR_W+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: rtl/csvft_back.sv
// ----------------------------------------------------------------------------
// csvft_back: tokenizer back end
// Runs the quote mode machine and the cell and byte counters on each
// classified item and loads any result into the output register.
// ----------------------------------------------------------------------------
module csvft_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [csvft_pkg::CFGI_W-1:0]    cfg_index,
	input  logic [csvft_pkg::CFGD_W-1:0]    cfg_data,
	input  logic                            q_valid,
	input  csvft_pkg::entry_t               q_head,
	output logic                            q_pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [csvft_pkg::TDATA_W-1:0]   m_tdata,
	output logic [csvft_pkg::KIND_W-1:0]    m_tuser
);

	localparam int CC_W = csvft_pkg::CC_W;
	localparam int BC_W = csvft_pkg::BC_W;

	logic [csvft_pkg::MAXC_W-1:0] max_cells_q;
	csvft_pkg::qmode_t            qm_q, n_qm;
	logic [BC_W-1:0]              bc_q, n_bc;
	logic [CC_W-1:0]              cc_q, n_cc;
	logic                         rs_q, n_rs;
	logic                         ov_q, n_ov;

	logic [CC_W-1:0]              lim;
	logic [CC_W:0]                cc_inc;
	logic                         cell_full;
	logic                         go_out;
	logic                         do_data;
	logic                         do_cell;
	logic                         do_row;
	logic                         do_clear;
	logic                         has_res;
	logic [csvft_pkg::KIND_W-1:0] res_kind;
	logic [csvft_pkg::BYTE_W-1:0] res_byte;
	logic [BC_W-1:0]              res_len;
	logic                         res_ov;
	logic [csvft_pkg::IDX_W-1:0]  res_idx;

	logic                         out_valid_q;
	logic [csvft_pkg::KIND_W-1:0] out_kind_q;
	logic [csvft_pkg::BYTE_W-1:0] out_byte_q;
	logic [csvft_pkg::IDX_W-1:0]  out_idx_q;
	logic [csvft_pkg::LEN_W-1:0]  out_len_q;
	logic                         out_ov_q;

	// Take the next item whenever the output register is free or draining
	assign q_pop = q_valid && (!out_valid_q || m_tready);

	// Cell limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cells_q <= csvft_pkg::MAXC_RST;
		end else if (cfg_we && cfg_index == csvft_pkg::REG_MAX_CELLS) begin
			max_cells_q <= cfg_data[csvft_pkg::MAXC_W-1:0];
		end
	end

	// Effective cell limit: zero reads as one, clamp to the row maximum
	always_comb begin
		if (max_cells_q == '0)
			lim = CC_W'(1);
		else if (32'(max_cells_q) > csvft_pkg::MAX_ROW_CELLS)
			lim = CC_W'(csvft_pkg::MAX_ROW_CELLS);
		else
			lim = CC_W'(max_cells_q);
	end

	assign cell_full = (cc_q >= lim);
	assign cc_inc    = {1'b0, cc_q} + 1'b1;
	assign res_idx   = (32'(cc_q) > 255) ? 8'hFF : cc_q[csvft_pkg::IDX_W-1:0];

	// Decide the action for the head item from the quote mode
	always_comb begin
		go_out   = 1'b0;
		do_data  = 1'b0;
		do_cell  = 1'b0;
		do_row   = 1'b0;
		do_clear = 1'b0;
		n_qm     = qm_q;
		n_rs     = rs_q;
		if (q_head.cls == csvft_pkg::CLS_EOI) begin
			do_clear = 1'b1;
		end else begin
			case (qm_q)
				csvft_pkg::QM_INSIDE: begin
					n_rs = 1'b1;
					if (q_head.cls == csvft_pkg::CLS_QUOTE)
						n_qm = csvft_pkg::QM_QSEEN;
					else
						do_data = 1'b1;
				end
				csvft_pkg::QM_QSEEN: begin
					if (q_head.cls == csvft_pkg::CLS_QUOTE) begin
						n_qm    = csvft_pkg::QM_INSIDE;
						do_data = 1'b1;
					end else begin
						n_qm   = csvft_pkg::QM_OUTSIDE;
						go_out = 1'b1;
					end
				end
				default: go_out = 1'b1;
			endcase
			if (go_out) begin
				case (q_head.cls)
					csvft_pkg::CLS_QUOTE: begin
						n_rs = 1'b1;
						n_qm = csvft_pkg::QM_INSIDE;
					end
					csvft_pkg::CLS_NEWLINE: do_row = 1'b1;
					csvft_pkg::CLS_DELIM: begin
						n_rs    = 1'b1;
						do_cell = 1'b1;
					end
					default: begin
						n_rs    = 1'b1;
						do_data = 1'b1;
					end
				endcase
			end
		end
	end

	// Counters, overflow and the result of the action
	always_comb begin
		n_bc     = bc_q;
		n_cc     = cc_q;
		n_ov     = ov_q;
		has_res  = 1'b0;
		res_kind = csvft_pkg::KIND_DATA;
		res_byte = '0;
		res_len  = bc_q;
		res_ov   = ov_q;
		if (do_clear) begin
			if (qm_q == csvft_pkg::QM_INSIDE) begin
				has_res  = 1'b1;
				res_kind = csvft_pkg::KIND_ABORT;
			end else if (rs_q || bc_q != '0) begin
				has_res  = 1'b1;
				res_kind = csvft_pkg::KIND_ROW_END;
				res_ov   = ov_q | cell_full;
			end
			n_bc = '0;
			n_cc = '0;
			n_ov = 1'b0;
		end else if (do_row) begin
			has_res  = 1'b1;
			res_kind = csvft_pkg::KIND_ROW_END;
			res_ov   = ov_q | cell_full;
			n_bc     = '0;
			n_cc     = '0;
			n_ov     = 1'b0;
		end else if (do_cell) begin
			has_res  = 1'b1;
			res_kind = csvft_pkg::KIND_CELL_END;
			res_ov   = ov_q | cell_full;
			n_ov     = res_ov;
			n_bc     = '0;
			n_cc     = (cc_inc > {1'b0, lim}) ? lim : cc_inc[CC_W-1:0];
		end else if (do_data) begin
			has_res  = 1'b1;
			res_kind = csvft_pkg::KIND_DATA;
			res_byte = q_head.data;
			if (32'(bc_q) >= csvft_pkg::MAX_CELL_BYTES)
				n_ov = 1'b1;
			else
				n_bc = bc_q + 1'b1;
			res_len = n_bc;
			res_ov  = n_ov;
		end
	end

	// Row state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qm_q <= csvft_pkg::QM_OUTSIDE;
			bc_q <= '0;
			cc_q <= '0;
			rs_q <= 1'b0;
			ov_q <= 1'b0;
		end else if (q_pop) begin
			qm_q <= (do_clear || do_row) ? csvft_pkg::QM_OUTSIDE : n_qm;
			bc_q <= n_bc;
			cc_q <= n_cc;
			rs_q <= (do_clear || do_row) ? 1'b0 : n_rs;
			ov_q <= n_ov;
		end
	end

	// Output valid: load on a result, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && has_res) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (q_pop && has_res) begin
			out_kind_q <= res_kind;
			out_byte_q <= res_byte;
			out_idx_q  <= res_idx;
			out_len_q  <= csvft_pkg::LEN_W'(res_len);
			out_ov_q   <= res_ov;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {2'b00, out_ov_q, out_len_q, out_idx_q, out_byte_q};

endmodule

// File: tb/sv/csv_field_tokenizer_unit_tb.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit_tb: self-checking bench for the CSV tokenizer
// Feeds CSV text and end-of-input marks through the s_ channel and checks
// every m_ result against a scoreboard filled by a cycle-free model of the
// quote machine, cell counters and overflow rules. Directed tests cover the
// quoting corner cases, delimiter clashes, cell limits and one long
// receiver hold-off; random phases send mostly well-formed records under
// several settings, with random idling on both sides in all but one phase.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_unit_tb;
	import csvft_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 55;

	// One result of the block, fields in report order
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [7:0]        data;
		logic [IDX_W-1:0]  idx;
		logic [LEN_W-1:0]  len;
		logic              ovf;
	} token_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [CFGI_W-1:0] cfg_index = '0;
	logic [CFGD_W-1:0] cfg_data  = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata   = '0;
	logic              s_tuser   = 1'b0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [31:0]       m_tdata;
	logic [1:0]        m_tuser;

	// Model of the block: configuration and row state
	logic [7:0]        delim_reg;
	logic [MAXC_W-1:0] cell_cap_reg;
	qmode_t            qmode;
	logic [LEN_W-1:0]  cell_bytes;
	logic [8:0]        row_cells;
	logic              row_open;
	logic              row_ovf;

	token_t pending_tokens[$];
	int     errors      = 0;
	int     items_sent  = 0;
	int     idle_cycles = 0;
	int     hold_left   = 0;
	bit     hold_req    = 1'b0;
	bit     calm        = 1'b0;

	csv_field_tokenizer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Tokenizer model
	// ------------------------------------------------------------------------

	// Effective cell limit: zero counts as one, clip at the row maximum
	function automatic logic [8:0] cell_cap();
		if (cell_cap_reg == 0)
			return 9'd1;
		if (cell_cap_reg > MAX_ROW_CELLS)
			return 9'(MAX_ROW_CELLS);
		return cell_cap_reg;
	endfunction

	task automatic clear_row();
		qmode      = QM_OUTSIDE;
		cell_bytes = '0;
		row_cells  = '0;
		row_open   = 1'b0;
		row_ovf    = 1'b0;
	endtask

	task automatic push_token(input logic [KIND_W-1:0] kind, input logic [7:0] data,
			input logic [LEN_W-1:0] len);
		token_t t;
		t.kind = kind;
		t.data = data;
		t.idx  = (row_cells > 255) ? 8'd255 : row_cells[7:0];
		t.len  = len;
		t.ovf  = row_ovf;
		pending_tokens.push_back(t);
	endtask

	// Count a content byte, saturating at the cell maximum
	task automatic content_byte(input logic [7:0] b);
		if (cell_bytes >= MAX_CELL_BYTES)
			row_ovf = 1'b1;
		else
			cell_bytes = cell_bytes + 1'b1;
		push_token(KIND_DATA, b, cell_bytes);
	endtask

	task automatic close_cell();
		logic [8:0] lim;
		lim = cell_cap();
		if (row_cells >= lim)
			row_ovf = 1'b1;
		push_token(KIND_CELL_END, 8'h00, cell_bytes);
		row_cells = row_cells + 1'b1;
		if (row_cells > lim)
			row_cells = lim;
		cell_bytes = '0;
	endtask

	task automatic close_row();
		if (row_cells >= cell_cap())
			row_ovf = 1'b1;
		push_token(KIND_ROW_END, 8'h00, cell_bytes);
		clear_row();
	endtask

	// Advance the model by one accepted item
	task automatic tokenize_byte(input logic [7:0] b, input logic eoi);
		if (eoi) begin
			if (qmode == QM_INSIDE) begin
				push_token(KIND_ABORT, 8'h00, cell_bytes);
				clear_row();
			end else if (row_open || cell_bytes != 0) begin
				close_row();
			end else begin
				clear_row();
			end
			return;
		end
		if (qmode == QM_INSIDE) begin
			row_open = 1'b1;
			if (b == CH_QUOTE)
				qmode = QM_QSEEN;
			else
				content_byte(b);
			return;
		end
		if (qmode == QM_QSEEN) begin
			if (b == CH_QUOTE) begin
				qmode = QM_INSIDE;
				content_byte(b);
				return;
			end
			qmode = QM_OUTSIDE;
		end
		if (b == CH_QUOTE) begin
			row_open = 1'b1;
			qmode    = QM_INSIDE;
		end else if (b == CH_NEWLINE) begin
			close_row();
		end else begin
			row_open = 1'b1;
			if (b == delim_reg)
				close_cell();
			else
				content_byte(b);
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver: check each result, drive m_tready with idling and hold-off
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : rx_side
		token_t want;
		token_t seen;
		if (arst_n && m_tvalid && m_tready) begin
			seen = {m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[28:16], m_tdata[29]};
			if (pending_tokens.size() == 0) begin
				errors++;
				$display("%0t: unexpected result kind %0d byte %02h index %0d length %0d ovf %0d",
					$time, seen.kind, seen.data, seen.idx, seen.len, seen.ovf);
			end else begin
				want = pending_tokens.pop_front();
				if (seen !== want) begin
					errors++;
					$display("%0t: mismatch expected kind %0d byte %02h index %0d length %0d ovf %0d",
						$time, want.kind, want.data, want.idx, want.len, want.ovf);
					$display("%0t:          actual   kind %0d byte %02h index %0d length %0d ovf %0d",
						$time, seen.kind, seen.data, seen.idx, seen.len, seen.ovf);
				end
			end
		end
		// Hold off for a long stretch on request, else idle at random
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 17);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("csv_field_tokenizer_unit test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sender and configuration
	// ------------------------------------------------------------------------

	// Offer one item, idling at random first, and wait for acceptance
	task automatic send_item(input logic [7:0] b, input logic eoi);
		while (!calm && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= eoi;
		tokenize_byte(b, eoi);
		items_sent++;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			send_item(txt[i], 1'b0);
	endtask

	task automatic send_eoi();
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	// Drop valid, wait for every result, then let the pipeline empty
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFGD_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_DELIMITER)
			delim_reg = data[7:0];
		else if (idx == REG_MAX_CELLS)
			cell_cap_reg = data;
	endtask

	// Byte that is plain cell content under the current delimiter
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(99) < 80)
				c = 8'($urandom_range(32, 126));
			else
				c = 8'($urandom_range(255));
		end while (c == CH_QUOTE || c == CH_NEWLINE || c == delim_reg);
		return c;
	endfunction

	// Quoted cell with doubled quotes, delimiters and newlines inside
	task automatic send_quoted_cell();
		int         n;
		int         r;
		logic [7:0] c;
		n = $urandom_range(0, 6);
		send_item(CH_QUOTE, 1'b0);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 20) begin
				send_item(CH_QUOTE, 1'b0);
				send_item(CH_QUOTE, 1'b0);
			end else if (r < 30) begin
				send_item(delim_reg, 1'b0);
			end else if (r < 40) begin
				send_item(CH_NEWLINE, 1'b0);
			end else if (r < 45) begin
				send_item(8'h0D, 1'b0);
			end else begin
				do
					c = 8'($urandom_range(255));
				while (c == CH_QUOTE);
				send_item(c, 1'b0);
			end
		end
		send_item(CH_QUOTE, 1'b0);
	endtask

	// One record of random cells, closed by a newline or end of input
	task automatic send_record();
		int ncells;
		int nbytes;
		ncells = $urandom_range(1, 5);
		for (int i = 0; i < ncells; i++) begin
			if (i > 0)
				send_item(delim_reg, 1'b0);
			if ($urandom_range(99) < 40) begin
				send_quoted_cell();
			end else begin
				nbytes = $urandom_range(0, 6);
				for (int j = 0; j < nbytes; j++)
					send_item(plain_char(), 1'b0);
			end
		end
		if ($urandom_range(99) < 6)
			send_eoi();
		else
			send_item(CH_NEWLINE, 1'b0);
	endtask

	// Unstructured bytes, rich in special characters
	task automatic send_noise();
		int n;
		int r;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 10)
				send_item(CH_QUOTE, 1'b0);
			else if (r < 20)
				send_item(CH_NEWLINE, 1'b0);
			else if (r < 30)
				send_item(delim_reg, 1'b0);
			else if (r < 35)
				send_eoi();
			else
				send_item(8'($urandom_range(255)), 1'b0);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Quoting corner cases under the reset configuration
	task automatic test_quoting();
		send_text("a,\"x\"\"y\",\n");
		send_text("\n");
		send_text("p\"q\"r\r,");
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hA5, 1'b1);
		send_eoi();
		send_text("\"ab");
		send_eoi();
		send_text("z,");
		send_eoi();
	endtask

	// Delimiter equal to quote or newline, NUL and 0xFF delimiters, ignored register indexes
	task automatic test_delimiter_clash();
		settle_block();
		write_reg(REG_DELIMITER, {1'b0, CH_QUOTE});
		send_text("a\"b\"c\n");
		settle_block();
		write_reg(REG_DELIMITER, {1'b1, CH_NEWLINE});
		send_text("a\nb");
		send_eoi();
		settle_block();
		write_reg(2'd2, 9'h1FF);
		write_reg(2'd3, 9'h000);
		send_text("a,b\n");
		settle_block();
		write_reg(REG_DELIMITER, 9'h000);
		send_item(8'h41, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h00, 1'b0);
		send_eoi();
		settle_block();
		write_reg(REG_DELIMITER, 9'h0FF);
		send_item(8'h7F, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(CH_NEWLINE, 1'b0);
		settle_block();
		write_reg(REG_DELIMITER, {1'b0, DELIM_RST});
	endtask

	// Cell count limit at both extremes and index saturation
	task automatic test_cell_limit();
		settle_block();
		write_reg(REG_MAX_CELLS, 9'd0);
		send_text("a,b,c\n");
		settle_block();
		write_reg(REG_MAX_CELLS, 9'd1);
		send_text(",\n");
		settle_block();
		write_reg(REG_MAX_CELLS, 9'd2);
		send_text("a,b,c,d\n");
		settle_block();
		write_reg(REG_MAX_CELLS, 9'd511);
		for (int i = 0; i < 300; i++)
			send_item(delim_reg, 1'b0);
		send_item(CH_NEWLINE, 1'b0);
		settle_block();
		write_reg(REG_MAX_CELLS, MAXC_RST);
	endtask

	// Receiver holds off while the sender keeps offering items
	task automatic test_backpressure();
		settle_block();
		hold_req = 1'b1;
		wait (hold_left != 0);
		calm = 1'b1;
		for (int i = 0; i < 40; i++)
			send_item(plain_char(), 1'b0);
		send_item(CH_NEWLINE, 1'b0);
		calm = 1'b0;
	endtask

	// Random records and noise under several settings
	task automatic test_random();
		logic [7:0]        delims [7] = '{8'h2C, 8'h09, 8'h00, 8'hFF, 8'h22, 8'h0A, 8'h7C};
		logic [MAXC_W-1:0] caps   [7] = '{9'd256, 9'd3, 9'd0, 9'd511, 9'd2, 9'd1, 9'd4};
		logic              top_bit;
		int                start;
		for (int p = 0; p < 7; p++) begin
			settle_block();
			top_bit = 1'($urandom_range(1));
			write_reg(REG_DELIMITER, {top_bit, delims[p]});
			write_reg(REG_MAX_CELLS, caps[p]);
			calm  = (p == 3);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				if ($urandom_range(99) < 85)
					send_record();
				else
					send_noise();
			end
			send_eoi();
		end
		calm = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		delim_reg    = DELIM_RST;
		cell_cap_reg = MAXC_RST;
		clear_row();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_quoting();
		test_delimiter_clash();
		test_cell_limit();
		test_backpressure();
		test_random();
		settle_block();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("csv_field_tokenizer_unit test passed");
		else
			$display("csv_field_tokenizer_unit test failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/csvft_pkg.sv
rtl/csvft_front.sv
rtl/csvft_queue.sv
rtl/csvft_back.sv
rtl/csv_field_tokenizer_unit.sv
tb/sv/csv_field_tokenizer_unit_tb.sv
